// File: design/swm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and control type for the sliding window maximum block.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 32;
	localparam int CFG_BITS        = 7;
	localparam logic [CFG_BITS-1:0] WINDOW_SIZE_RST = CFG_BITS'(3);

	// broadcast to every cell of the chain
	typedef struct packed {
		logic restart;  // beat starts a new sequence
		logic insert;   // beat accepted: prune and append
		logic shift;    // front leaves, chain moves one cell forward
		logic load;     // cells take their next contents
	} swm_ctrl_t;

endpackage

// File: design/swm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_cell
// One deque slot: holds a candidate, prunes it against the new sample and
// takes its back neighbor's contents when the chain shifts.
// ----------------------------------------------------------------------------
module swm_cell #(
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
	parameter int POS_BITS    = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  swm_pkg::swm_ctrl_t            ctrl,
	input  logic signed [SAMPLE_BITS-1:0] x,
	input  logic        [POS_BITS-1:0]    x_pos,
	input  logic                          link_in,
	input  logic                          ret_in,
	output logic                          link_out,
	input  logic                          nb_valid,
	input  logic signed [SAMPLE_BITS-1:0] nb_val,
	input  logic        [POS_BITS-1:0]    nb_pos,
	output logic                          f_valid,
	output logic signed [SAMPLE_BITS-1:0] f_val,
	output logic        [POS_BITS-1:0]    f_pos,
	output logic                          cur_valid,
	output logic        [POS_BITS-1:0]    cur_pos
);

	logic                          valid_q;
	logic signed [SAMPLE_BITS-1:0] val_q;
	logic        [POS_BITS-1:0]    pos_q;
	logic                          v_eff;
	logic                          weaker;
	logic                          keep;
	logic                          take_x;

	assign v_eff    = valid_q && !ctrl.restart;
	assign weaker   = ctrl.insert && (val_q < x);
	assign keep     = v_eff && !weaker && !ret_in;
	// first slot past the kept run receives the new sample
	assign take_x   = !keep && link_in && ctrl.insert;
	assign link_out = keep || ret_in;

	assign f_valid  = keep || take_x;
	assign f_val    = keep ? val_q : x;
	assign f_pos    = keep ? pos_q : x_pos;

	assign cur_valid = valid_q;
	assign cur_pos   = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.load) begin
			valid_q <= ctrl.shift ? nb_valid : f_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			val_q <= ctrl.shift ? nb_val : f_val;
			pos_q <= ctrl.shift ? nb_pos : f_pos;
		end
	end

endmodule

// File: design/sliding_window_max.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_max
// Running maximum of the last window_size signed samples, kept as a
// monotonic deque in a chain of cells (front in cell 0).
//
//  port group  dir  beat contents
//  s_*         in   tdata: sample; tuser: restart
//  m_*         out  tdata: window_max
//  cfg_*       in   window_size write
//
// One sample per cycle while s_tready is high; all cells prune against the
// sample in parallel and the chain moves at most one cell per cycle. After
// window_size shrinks, the chain drops one stale front candidate per cycle
// with s_tready low before the next sample. Reset empties the chain and sets
// window_size to 3. s_tready follows m_tready while a result is held.
// ----------------------------------------------------------------------------
module sliding_window_max #(
	parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // sample
	input  logic                                s_tuser,  // restart
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,  // window_max
	input  logic                                cfg_we,
	input  logic [swm_pkg::CFG_BITS-1:0]        cfg_wdata
);

	localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int POS_MOD    = 2 * WINDOW_MAX;
	localparam int POS_BITS   = $clog2(POS_MOD);

	logic [swm_pkg::CFG_BITS-1:0]  ws_q;
	logic [POS_BITS-1:0]           k;
	logic [POS_BITS-1:0]           pos_q;
	logic                          filled_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] wmax_q;

	logic signed [SAMPLE_BITS-1:0] x;
	logic                          acc;
	logic                          ret;
	logic                          need_drain;
	logic [POS_BITS:0]             age_diff;
	logic [POS_BITS-1:0]           front_age;
	logic [POS_BITS-1:0]           pos_eff;
	logic [POS_BITS-1:0]           pos_next;
	logic                          filled_next;
	swm_pkg::swm_ctrl_t            ctrl;

	logic [WINDOW_MAX:0]           f_valid;
	logic signed [SAMPLE_BITS-1:0] f_val [0:WINDOW_MAX];
	logic [POS_BITS-1:0]           f_pos [0:WINDOW_MAX];
	logic [WINDOW_MAX-1:0]         link;
	logic [WINDOW_MAX-1:0]         cur_valid;
	logic [POS_BITS-1:0]           cur_pos [0:WINDOW_MAX-1];

	always_comb begin
		if (ws_q == '0) begin
			k = POS_BITS'(1);
		end else if (32'(ws_q) > WINDOW_MAX) begin
			k = POS_BITS'(WINDOW_MAX);
		end else begin
			k = POS_BITS'(ws_q);
		end
	end

	assign x = s_tdata[SAMPLE_BITS-1:0];

	// front age, modulo the position range
	assign age_diff  = {1'b0, pos_q} - {1'b0, cur_pos[0]};
	assign front_age = age_diff[POS_BITS] ?
		POS_BITS'(age_diff + (POS_BITS+1)'(POS_MOD)) : age_diff[POS_BITS-1:0];

	assign need_drain = cur_valid[0] && (front_age > k);
	assign s_tready   = !need_drain && (!out_valid_q || m_tready);
	assign acc        = s_tvalid && s_tready;
	assign ret        = acc && !s_tuser && cur_valid[0] && (front_age >= k);

	assign ctrl.restart = acc && s_tuser;
	assign ctrl.insert  = acc;
	assign ctrl.shift   = ret || need_drain;
	assign ctrl.load    = acc || need_drain;

	assign pos_eff  = s_tuser ? '0 : pos_q;
	assign pos_next = (pos_eff == POS_BITS'(POS_MOD - 1)) ? '0 : pos_eff + POS_BITS'(1);
	assign filled_next = (filled_q && !s_tuser) ||
		(({1'b0, pos_eff} + (POS_BITS+1)'(1)) >= {1'b0, k});

	// slot past the last cell: a full chain that shifts takes the sample here
	assign f_valid[WINDOW_MAX] = link[WINDOW_MAX-1] && ctrl.insert;
	assign f_val[WINDOW_MAX]   = x;
	assign f_pos[WINDOW_MAX]   = pos_eff;

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic link_in;
		logic ret_in;
		if (i == 0) begin : g_front
			assign link_in = !ret;
			assign ret_in  = ret;
		end else begin : g_rest
			assign link_in = link[i-1];
			assign ret_in  = 1'b0;
		end
		swm_cell #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.POS_BITS   (POS_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.x        (x),
			.x_pos    (pos_eff),
			.link_in  (link_in),
			.ret_in   (ret_in),
			.link_out (link[i]),
			.nb_valid (f_valid[i+1]),
			.nb_val   (f_val[i+1]),
			.nb_pos   (f_pos[i+1]),
			.f_valid  (f_valid[i]),
			.f_val    (f_val[i]),
			.f_pos    (f_pos[i]),
			.cur_valid(cur_valid[i]),
			.cur_pos  (cur_pos[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q        <= swm_pkg::WINDOW_SIZE_RST;
			pos_q       <= '0;
			filled_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ws_q <= cfg_wdata;
			end
			if (acc) begin
				pos_q       <= pos_next;
				filled_q    <= filled_next;
				out_valid_q <= filled_next;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			wmax_q <= ret ? f_val[1] : f_val[0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDATA_BITS'(unsigned'(wmax_q));

	// candidates always occupy a run of cells starting at the front
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((cur_valid + WINDOW_MAX'(1)) & cur_valid) == '0)
		else $error("deque cells not contiguous");

	a_front_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> cur_valid[0])
		else $error("deque empty after a sample");

	a_restart_pos: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_tuser |=> pos_q == POS_BITS'(1))
		else $error("restart did not reset position");

	a_age_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cur_valid[0] |-> front_age <= k)
		else $error("stale front candidate at sample");

endmodule

// File: tb/sliding_window_max_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_max_tb
// Drives signed sample beats with random restarts through the block and
// checks every window maximum against a deque model kept in the bench.
// Window size is rewritten between phases, including 0, 1, 64 and values
// above the limit. Some phases shrink the window without a restart. Both
// sides stall at random, and each phase may switch off either side's stalls.
// ----------------------------------------------------------------------------
module sliding_window_max_tb;

	localparam int SW   = swm_pkg::SAMPLE_BITS_DEF;
	localparam int WMAX = swm_pkg::WINDOW_MAX_DEF;
	localparam int DW   = ((SW + 7) / 8) * 8;
	localparam int CW   = swm_pkg::CFG_BITS;
	localparam int PW   = $clog2(2 * WMAX);

	typedef struct packed {
		logic [SW-1:0] value;
		logic          restart;
	} sample_beat_t;

	typedef enum int {RUN_RANDOM, RUN_NARROW, RUN_FALLING, RUN_RISING, RUN_EXTREME} run_kind_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          s_tvalid  = 1'b0;
	logic          s_tready;
	logic [DW-1:0] s_tdata   = '0;  // sample
	logic          s_tuser   = 1'b0;  // restart
	logic          m_tvalid;
	logic          m_tready  = 1'b0;
	logic [DW-1:0] m_tdata;  // window_max
	logic          cfg_we    = 1'b0;
	logic [CW-1:0] cfg_wdata = '0;

	sliding_window_max DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	sample_beat_t  pending_samples[$];
	logic [SW-1:0] expected_max[$];

	// bench copy of the deque
	logic [SW-1:0] cand_value[$];
	logic [PW-1:0] cand_pos[$];
	logic [PW-1:0] seq_pos      = '0;
	bit            window_full  = 1'b0;
	logic [CW-1:0] window_cfg   = swm_pkg::WINDOW_SIZE_RST;

	int            errors       = 0;
	bit            tx_idle_en   = 1'b1;
	bit            rx_idle_en   = 1'b1;
	int            tx_gap       = 0;
	int            rx_hold      = 0;
	run_kind_t     run_kind     = RUN_RANDOM;
	int            run_left     = 0;
	logic [SW-1:0] trend        = '0;

	function automatic int idle_len(bit enabled);
		int r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void predict_window_max(logic [SW-1:0] smp, logic restart);
		int            span;
		logic [PW-1:0] age;
		span = window_cfg;
		if (span < 1)
			span = 1;
		if (span > WMAX)
			span = WMAX;
		if (restart) begin
			cand_value.delete();
			cand_pos.delete();
			seq_pos = '0;
			window_full = 1'b0;
		end
		while (cand_value.size() > 0) begin
			age = seq_pos - cand_pos[0];
			if (age < span)
				break;
			cand_value.delete(0);
			cand_pos.delete(0);
		end
		while (cand_value.size() > 0 && $signed(cand_value[$]) < $signed(smp)) begin
			cand_value.delete(cand_value.size() - 1);
			cand_pos.delete(cand_pos.size() - 1);
		end
		if (cand_value.size() < WMAX) begin
			cand_value.insert(cand_value.size(), smp);
			cand_pos.insert(cand_pos.size(), seq_pos);
		end
		if (int'(seq_pos) + 1 >= span)
			window_full = 1'b1;
		seq_pos = seq_pos + PW'(1);
		if (window_full)
			expected_max.insert(expected_max.size(), cand_value[0]);
	endfunction

	function automatic sample_beat_t make_random_beat(int restart_odds);
		sample_beat_t b;
		if (run_left == 0) begin
			run_kind = run_kind_t'($urandom_range(0, 4));
			run_left = $urandom_range(4, 80);
		end
		run_left--;
		case (run_kind)
			RUN_RANDOM: trend = $urandom();
			RUN_NARROW: trend = SW'($urandom_range(0, 8)) - SW'(4);
			RUN_FALLING: trend = trend - SW'($urandom_range(0, 3000));
			RUN_RISING: trend = trend + SW'($urandom_range(0, 3000));
			default: begin
				case ($urandom_range(0, 3))
					0: trend = {1'b1, {(SW-1){1'b0}}};
					1: trend = {1'b0, {(SW-1){1'b1}}};
					2: trend = '0;
					default: trend = '1;
				endcase
			end
		endcase
		b.value = trend;
		b.restart = ($urandom_range(1, restart_odds) == 1);
		return b;
	endfunction

	// driver
	always @(posedge clk) begin
		sample_beat_t b;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_window_max(s_tdata[SW-1:0], s_tuser);
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					b = pending_samples[0];
					pending_samples.delete(0);
					s_tvalid <= 1'b1;
					s_tdata <= DW'(b.value);
					s_tuser <= b.restart;
					tx_gap = idle_len(tx_idle_en);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		logic [SW-1:0] want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_max.size() == 0) begin
					$error("window_max: unexpected beat, expected none, actual %0d",
						$signed(m_tdata[SW-1:0]));
					errors++;
				end else begin
					want = expected_max[0];
					expected_max.delete(0);
					if (m_tdata[SW-1:0] !== want) begin
						$error("window_max: expected %0d, actual %0d",
							$signed(want), $signed(m_tdata[SW-1:0]));
						errors++;
					end
				end
			end
			if (rx_hold > 0) begin
				rx_hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				rx_hold = idle_len(rx_idle_en);
			end
		end
	end

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_samples.size() != 0 || s_tvalid || expected_max.size() != 0);
	endtask

	task automatic write_window(logic [CW-1:0] size);
		wait_drained();
		// samples that gave no result may still be in the chain
		repeat (10) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= size;
		@(posedge clk);
		cfg_we <= 1'b0;
		window_cfg = size;
	endtask

	task automatic push_beat(logic [SW-1:0] value, logic restart);
		sample_beat_t b;
		b.value = value;
		b.restart = restart;
		pending_samples.insert(pending_samples.size(), b);
	endtask

	initial begin
		int window_plan[15];
		int ph;
		int n;
		int restart_odds;
		window_plan = '{0, 1, 127, 64, 2, 64, 5, 33, 3, -1, 16, 64, 1, 7, -1};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset window of three
		push_beat(32'h7FFF_FFFF, 1'b1);
		push_beat(32'h8000_0000, 1'b0);
		push_beat(32'h0000_0000, 1'b0);
		push_beat(32'hFFFF_FFFF, 1'b0);
		push_beat(32'd5, 1'b0);
		push_beat(32'd5, 1'b0);
		push_beat(32'd5, 1'b0);
		push_beat(32'd1, 1'b0);
		push_beat(32'd2, 1'b0);
		push_beat(32'd3, 1'b0);
		push_beat(32'd4, 1'b0);
		push_beat(32'd10, 1'b0);
		push_beat(32'd9, 1'b0);
		push_beat(32'd8, 1'b0);
		push_beat(32'd7, 1'b0);
		push_beat(32'h8000_0000, 1'b1);
		push_beat(32'h8000_0000, 1'b0);
		push_beat(32'h8000_0000, 1'b0);
		push_beat(32'h8000_0001, 1'b0);
		push_beat(32'd7, 1'b1);
		push_beat(32'd8, 1'b0);
		push_beat(32'h7FFF_FFFF, 1'b1);
		push_beat(32'hFFFF_FFFE, 1'b0);
		push_beat(32'h7FFF_FFFF, 1'b0);
		push_beat(32'h7FFF_FFFF, 1'b0);

		for (ph = 0; ph < 15; ph++) begin
			if (window_plan[ph] < 0)
				write_window(CW'($urandom_range(0, 127)));
			else
				write_window(CW'(window_plan[ph]));
			tx_idle_en = ($urandom_range(0, 3) != 0);
			rx_idle_en = ($urandom_range(0, 3) != 0);
			restart_odds = (ph == 8 || ph == 13) ? 4 : 60;
			for (n = 0; n < 122; n++)
				pending_samples.insert(pending_samples.size(),
					make_random_beat(restart_odds));
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (expected_max.size() != 0) begin
			$error("window_max: %0d expected beats never arrived", expected_max.size());
			errors++;
		end
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
